>>> design/asae_pkg.sv
// shared types and constants for the adaptive step auto exposure block
package asae_pkg;

  localparam int CfgAddrWidth = 4;

  localparam logic [7:0] ExpHighGuard = 8'hF5;
  localparam logic [7:0] ExpLowGuard  = 8'h10;
  localparam logic [7:0] ExpMax       = 8'hFF;
  localparam logic [7:0] ExpMin       = 8'h01;
  localparam logic [7:0] ExpReset     = 8'h80;
  localparam logic [7:0] StepReset    = 8'd16;
  localparam logic [7:0] StepMax      = 8'd255;
  localparam logic [7:0] MinLumaReset = 8'd80;
  localparam logic [7:0] MaxLumaReset = 8'd130;

  typedef enum logic [1:0] {
    REG_MIN_LUMA  = 2'd0,
    REG_MAX_LUMA  = 2'd1,
    REG_AE_ENABLE = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_PROCESSED = 2'd0,
    ST_NO_LUMA   = 2'd1,
    ST_DISABLED  = 2'd2
  } status_t;

  typedef enum logic {
    DIR_DOWN = 1'b0,
    DIR_UP   = 1'b1
  } dir_t;

  typedef struct packed {
    logic [7:0] luma_avg;
    logic       luma_valid;
  } src_beat_t;

  typedef struct packed {
    logic [7:0] exposure_out;
    logic       exposure_write;
    status_t    status;
  } dst_beat_t;

endpackage

>>> design/adaptive_step_auto_exposure.sv
// top level of the adaptive step auto exposure block
//
// one source beat carries a frame's average luma and a flag that says whether
// it is available; each source beat yields exactly one destination beat with
// the updated exposure, a sensor write strobe and a status code.
// a beat is taken into an input register, and the exposure, step and direction
// update runs combinationally into the output register, so destination valid
// rises once the beat has passed the input and the output register; one beat per
// cycle is sustained while the destination does not stall, and the update loop
// through the exposure and step registers sets that rate.
// the output register is released when the receiver does not stall, and the
// input register moves on in the same cycle, so a stall on the destination
// reaches src_stall only once both registers are full.
// registers on the apb port: min_luma at 0x0, max_luma at 0x4, soft_ae_enable
// at 0x8; write them only while no beat is in flight.
// reset (synchronous, active high) empties both registers, sets exposure to
// 0x80, step to 16, direction down, and loads the register defaults.
module adaptive_step_auto_exposure
  import asae_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    src_valid,
  output logic                    src_stall,
  input  src_beat_t               src_beat,
  output logic                    dst_valid,
  input  logic                    dst_stall,
  output dst_beat_t               dst_beat,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [7:0] min_luma;
  logic [7:0] max_luma;
  logic       soft_ae_enable;

  logic [7:0] exposure;
  logic [7:0] exposure_next;
  logic [7:0] step_size;
  logic [7:0] step_size_next;
  dir_t       last_direction;
  dir_t       last_direction_next;

  logic       s1_valid;
  src_beat_t  s1_beat;
  logic       s1_move;
  logic       dst_free;
  dst_beat_t  dst_beat_next;

  reg_index_t cfg_index;
  logic       cfg_write;

  // config port
  assign pready    = 1'b1;
  assign cfg_index = reg_index_t'(paddr[CfgAddrWidth-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_luma       <= MinLumaReset;
      max_luma       <= MaxLumaReset;
      soft_ae_enable <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_LUMA:  min_luma       <= pwdata[7:0];
        REG_MAX_LUMA:  max_luma       <= pwdata[7:0];
        REG_AE_ENABLE: soft_ae_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_MIN_LUMA:  prdata = {24'd0, min_luma};
      REG_MAX_LUMA:  prdata = {24'd0, max_luma};
      REG_AE_ENABLE: prdata = {31'd0, soft_ae_enable};
      default:       prdata = 32'd0;
    endcase
  end

  // handshake
  assign dst_free  = !dst_valid || !dst_stall;
  assign s1_move   = s1_valid && dst_free;
  assign src_stall = s1_valid && !dst_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!src_stall) begin
      s1_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      s1_beat <= src_beat;
    end
  end

  // exposure update
  always_comb begin
    logic [8:0] sum;
    logic [7:0] e1;
    logic [7:0] st1;
    dir_t       d1;
    logic       dark;
    logic       stop;
    logic       bright;
    logic       wrote;
    logic [8:0] step_inc;

    e1       = exposure;
    st1      = step_size;
    d1       = last_direction;
    wrote    = 1'b0;
    sum      = 9'd0;
    step_inc = 9'd0;
    dark     = s1_beat.luma_avg < min_luma;
    stop     = dark && (exposure > ExpHighGuard);

    exposure_next       = exposure;
    step_size_next      = step_size;
    last_direction_next = last_direction;
    dst_beat_next       = '0;

    if (dark && !stop) begin
      sum = {1'b0, exposure} + {1'b0, step_size};
      if (sum > {1'b0, ExpMax}) begin
        e1 = ExpMax;
      end else if (sum[7:0] < ExpMin) begin
        e1 = ExpMin;
      end else begin
        e1 = sum[7:0];
      end
      if (last_direction != DIR_UP) begin
        st1 = step_size >> 1;
      end else begin
        step_inc = {1'b0, step_size} + 9'd2;
        st1 = (step_inc > {1'b0, StepMax}) ? StepMax : step_inc[7:0];
      end
      d1    = DIR_UP;
      wrote = 1'b1;
    end

    bright = !stop && (s1_beat.luma_avg > max_luma) && (e1 >= ExpLowGuard);

    if (!soft_ae_enable) begin
      dst_beat_next.status = ST_DISABLED;
    end else if (!s1_beat.luma_valid) begin
      dst_beat_next.status = ST_NO_LUMA;
    end else begin
      dst_beat_next.status = ST_PROCESSED;
      exposure_next        = e1;
      step_size_next       = st1;
      last_direction_next  = d1;
      if (bright) begin
        if ({1'b0, st1} + {1'b0, ExpMin} > {1'b0, e1}) begin
          exposure_next = ExpMin;
        end else begin
          exposure_next = e1 - st1;
        end
        if (d1 != DIR_DOWN) begin
          step_size_next = st1 >> 1;
        end else begin
          step_inc = {1'b0, st1} + 9'd2;
          step_size_next = (step_inc > {1'b0, StepMax}) ? StepMax : step_inc[7:0];
        end
        last_direction_next = DIR_DOWN;
        wrote = 1'b1;
      end
      dst_beat_next.exposure_write = wrote;
    end
    dst_beat_next.exposure_out = exposure_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exposure       <= ExpReset;
      step_size      <= StepReset;
      last_direction <= DIR_DOWN;
    end else if (s1_move) begin
      exposure       <= exposure_next;
      step_size      <= step_size_next;
      last_direction <= last_direction_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (dst_free) begin
      dst_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      dst_beat <= dst_beat_next;
    end
  end

  // checks
  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> dst_beat.exposure_out == exposure)
    else $error("result exposure differs from held exposure");

  a_move_never_zero: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_beat.exposure_write |-> dst_beat.exposure_out != 8'd0)
    else $error("exposure move produced zero");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    dst_valid && (dst_beat.status == ST_DISABLED || dst_beat.status == ST_NO_LUMA)
      |-> !dst_beat.exposure_write)
    else $error("write strobe on a beat without an update");

  a_hold_when_disabled: assert property (@(posedge clk) disable iff (rst)
    s1_move && !soft_ae_enable |=> $stable(exposure) && $stable(step_size))
    else $error("state changed while loop disabled");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> s1_valid && dst_valid)
    else $error("source stalled with room in the pipeline");

endmodule

>>> sim/tb.sv
// self-checking testbench for the adaptive step auto exposure block
module tb;
  import asae_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    src_valid = 1'b0;
  logic                    src_stall;
  src_beat_t               src_beat = '0;
  logic                    dst_valid;
  logic                    dst_stall = 1'b0;
  dst_beat_t               dst_beat;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CfgAddrWidth-1:0] paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  adaptive_step_auto_exposure dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_beat  (src_beat),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_beat  (dst_beat),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // predictor copy of the block state and registers
  logic [7:0] cfg_min = MinLumaReset;
  logic [7:0] cfg_max = MaxLumaReset;
  logic       cfg_enable = 1'b1;
  logic [7:0] ae_exposure = ExpReset;
  logic [7:0] ae_step = StepReset;
  dir_t       ae_dir = DIR_DOWN;

  src_beat_t frame_queue[$];
  dst_beat_t exposure_due[$];
  int        queued = 0;
  int        accepted = 0;
  int        errors = 0;
  int        n_checked = 0;
  int        n_writes = 0;
  int        n_held = 0;
  int        n_settings = 0;
  logic      calm = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void adapt_step(dir_t dir);
    if (dir != ae_dir) begin
      ae_step = ae_step >> 1;
    end else if (ae_step > StepMax - 8'd2) begin
      ae_step = StepMax;
    end else begin
      ae_step = ae_step + 8'd2;
    end
    ae_dir = dir;
  endfunction

  function automatic dst_beat_t next_exposure(src_beat_t frame);
    dst_beat_t  res;
    logic [8:0] sum;
    logic       guard_stop;
    res.exposure_write = 1'b0;
    res.status = ST_PROCESSED;
    guard_stop = 1'b0;
    if (!cfg_enable) begin
      res.status = ST_DISABLED;
    end else if (!frame.luma_valid) begin
      res.status = ST_NO_LUMA;
    end else begin
      if (frame.luma_avg < cfg_min) begin
        if (ae_exposure > ExpHighGuard) begin
          guard_stop = 1'b1;
        end else begin
          sum = {1'b0, ae_exposure} + {1'b0, ae_step};
          ae_exposure = (sum > {1'b0, ExpMax}) ? ExpMax : sum[7:0];
          if (ae_exposure < ExpMin) ae_exposure = ExpMin;
          res.exposure_write = 1'b1;
          adapt_step(DIR_UP);
        end
      end
      if (!guard_stop && frame.luma_avg > cfg_max && ae_exposure >= ExpLowGuard) begin
        if ({1'b0, ae_step} + {1'b0, ExpMin} > {1'b0, ae_exposure}) begin
          ae_exposure = ExpMin;
        end else begin
          ae_exposure = ae_exposure - ae_step;
        end
        res.exposure_write = 1'b1;
        adapt_step(DIR_DOWN);
      end
    end
    res.exposure_out = ae_exposure;
    return res;
  endfunction

  task automatic check_beat(dst_beat_t got);
    dst_beat_t want;
    n_checked++;
    if (got.exposure_write === 1'b1) n_writes++;
    if (got.status !== ST_PROCESSED) n_held++;
    if (exposure_due.size() == 0) begin
      $display("%0t: unexpected beat exposure=%0d write=%0d status=%0d",
               $time, got.exposure_out, got.exposure_write, got.status);
      errors++;
    end else begin
      want = exposure_due.pop_front();
      if (got.exposure_out !== want.exposure_out) begin
        $display("%0t: exposure_out expected %0d got %0d",
                 $time, want.exposure_out, got.exposure_out);
        errors++;
      end
      if (got.exposure_write !== want.exposure_write) begin
        $display("%0t: exposure_write expected %0d got %0d",
                 $time, want.exposure_write, got.exposure_write);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        errors++;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else begin
      if (src_valid && !src_stall) begin
        exposure_due.push_back(next_exposure(src_beat));
        accepted++;
      end
      if (!src_valid || !src_stall) begin
        if (frame_queue.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
          src_beat <= frame_queue.pop_front();
          src_valid <= 1'b1;
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      dst_stall <= 1'b0;
    end else begin
      if (dst_valid && !dst_stall) check_beat(dst_beat);
      dst_stall <= !calm && ($urandom_range(99) < 25);
    end
  end

  function automatic void send(logic [7:0] luma, logic valid);
    src_beat_t frame;
    frame.luma_avg = luma;
    frame.luma_valid = valid;
    frame_queue.push_back(frame);
    queued++;
  endfunction

  function automatic logic [7:0] dark_luma();
    if (cfg_min == 8'd0) return 8'($urandom);
    return 8'($urandom_range(int'(cfg_min) - 1, 0));
  endfunction

  function automatic logic [7:0] bright_luma();
    if (cfg_max == 8'd255) return 8'($urandom);
    return 8'($urandom_range(255, int'(cfg_max) + 1));
  endfunction

  task automatic drain();
    while (accepted != queued || exposure_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(reg_index_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MIN_LUMA:  cfg_min = value[7:0];
      REG_MAX_LUMA:  cfg_max = value[7:0];
      REG_AE_ENABLE: cfg_enable = value[0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(logic [7:0] lo, logic [7:0] hi, logic en);
    cfg_write(REG_MIN_LUMA, {24'($urandom), lo});
    cfg_write(REG_MAX_LUMA, {24'($urandom), hi});
    cfg_write(REG_AE_ENABLE, {31'($urandom), en});
    n_settings++;
  endtask

  initial begin : stimulus
    int         made;
    int         len;
    int         kind;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] luma;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // wide crossed window: runs to both rails, guards, crossed thresholds, step to zero
    set_thresholds(8'd200, 8'd10, 1'b1);
    repeat (7) send(8'd255, 1'b1);
    repeat (11) send(8'd0, 1'b1);
    send(8'd100, 1'b1);
    send(8'd250, 1'b1);
    send(8'd100, 1'b1);
    repeat (2) begin
      send(8'd0, 1'b1);
      send(8'd255, 1'b1);
    end
    drain();

    set_thresholds(MinLumaReset, MaxLumaReset, 1'b0);
    send(8'd0, 1'b1);
    send(8'd255, 1'b0);
    drain();

    cfg_write(REG_AE_ENABLE, 32'd1);
    send(8'd100, 1'b1);
    send(8'd0, 1'b0);
    send(8'd255, 1'b0);
    drain();

    for (int ph = 0; ph < 20; ph++) begin
      case (ph)
        1: begin lo = 8'd0;   hi = 8'd255; end
        2: begin lo = 8'd255; hi = 8'd0;   end
        3: begin lo = 8'd0;   hi = 8'd0;   end
        4: begin lo = 8'd255; hi = 8'd255; end
        default: begin
          lo = 8'($urandom);
          hi = 8'($urandom);
          if (lo > hi && $urandom_range(2) != 0) begin
            luma = lo;
            lo = hi;
            hi = luma;
          end
        end
      endcase
      set_thresholds(lo, hi, (ph % 7) != 5);
      calm = (ph == 8);
      made = 0;
      while (made < 100) begin
        if (ph == 12 && made >= 50 && made < 60) begin
          // sender holds off until the pipeline is empty
          drain();
          made = 60;
        end
        kind = $urandom_range(9);
        len = $urandom_range(14, 1);
        for (int k = 0; k < len; k++) begin
          if (kind < 4) luma = dark_luma();
          else if (kind < 8) luma = bright_luma();
          else luma = 8'($urandom);
          send(luma, $urandom_range(11) != 0);
        end
        made += len;
      end
      drain();
      calm = 1'b0;
    end

    $display("checked %0d exposure beats over %0d threshold settings", n_checked, n_settings);
    $display("%0d sensor writes, %0d frames held for missing luma or loop off",
             n_writes, n_held);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
